// ----- design/tccw_pkg.sv -----
// shared types and constants for the text console cell writer
`timescale 1ns / 1ps

package tccw_pkg;

    // fixed field widths of the request and result ports
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // character codes and register reset value
    localparam logic [CHAR_W-1:0] NEWLINE_CODE       = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE         = 8'd32;
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // classified operation handed from front to back
    typedef struct packed {
        cmd_t              kind;
        logic              write_en;
        logic              scroll;
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
    } op_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_READ,
        B_COPY,
        B_DRAIN,
        B_FILL
    } back_state_t;

endpackage

// ----- design/tccw_front.sv -----
// front end: accepts requests, owns cursor and default attribute, classifies each request
`timescale 1ns / 1ps

module tccw_front #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80,
    localparam int AW     = $clog2(ROWS * COLUMNS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tccw_pkg::CMD_W-1:0]  command,
    input  logic [tccw_pkg::CHAR_W-1:0] char_code,
    input  logic                        use_position,
    input  logic [tccw_pkg::ROW_W-1:0]  row,
    input  logic [tccw_pkg::COL_W-1:0]  column,
    input  logic [tccw_pkg::ATTR_W-1:0] attribute,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tccw_pkg::ATTR_W-1:0] cfg_data,
    input  logic                        init_done,
    input  logic                        q_ready,
    output logic                        q_push,
    output tccw_pkg::op_t               q_op,
    output logic [AW-1:0]               q_addr
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    logic [RW-1:0]               cur_row_reg, cur_row_next;
    logic [CW-1:0]               cur_col_reg, cur_col_next;
    logic [tccw_pkg::ATTR_W-1:0] def_attr_reg;

    tccw_pkg::cmd_t              cmd;
    logic [RW-1:0]               row_sat, pos_row, nxt_row;
    logic [CW-1:0]               col_sat, pos_col, nxt_col;
    logic [tccw_pkg::ATTR_W-1:0] attr_sel;
    logic                        is_newline, last_col, at_bottom;
    logic [AW-1:0]               pos_addr, sat_addr;

    assign cfg_ready = 1'b1;
    assign in_ready  = init_done && q_ready;
    assign q_push    = in_valid && in_ready;

    // saturate the given position and pick the put attribute
    always_comb
    begin
        cmd = tccw_pkg::cmd_t'(command);
        if (32'(row) >= ROWS)
            row_sat = RW'(ROWS - 1);
        else
            row_sat = RW'(row);
        if (32'(column) >= COLUMNS)
            col_sat = CW'(COLUMNS - 1);
        else
            col_sat = CW'(column);
        attr_sel   = (attribute != '0) ? attribute : def_attr_reg;
        is_newline = (char_code == tccw_pkg::NEWLINE_CODE);
    end

    // put position, newline jump and advance with scroll detection
    always_comb
    begin
        pos_row  = use_position ? row_sat : cur_row_reg;
        pos_col  = use_position ? col_sat : cur_col_reg;
        pos_addr = AW'(32'(pos_row) * COLUMNS + 32'(pos_col));
        sat_addr = AW'(32'(row_sat) * COLUMNS + 32'(col_sat));
        last_col  = is_newline || (pos_col == CW'(COLUMNS - 1));
        at_bottom = (pos_row == RW'(ROWS - 1));
        if (last_col)
        begin
            nxt_col = '0;
            nxt_row = at_bottom ? pos_row : RW'(pos_row + 1'b1);
        end
        else
        begin
            nxt_col = CW'(pos_col + 1'b1);
            nxt_row = pos_row;
        end
    end

    // build the operation and the cursor after it
    always_comb
    begin
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        q_op.kind        = cmd;
        q_op.write_en    = 1'b0;
        q_op.scroll      = 1'b0;
        q_op.cell_data   = {attr_sel, char_code};
        q_addr           = pos_addr;
        case (cmd)
            tccw_pkg::CMD_PUT:
            begin
                q_op.write_en = !is_newline;
                q_op.scroll   = last_col && at_bottom;
                cur_row_next  = nxt_row;
                cur_col_next  = nxt_col;
            end
            tccw_pkg::CMD_READ:
            begin
                q_addr = sat_addr;
            end
            tccw_pkg::CMD_CLEAR:
            begin
                q_op.cell_data = {def_attr_reg, tccw_pkg::SPACE_CODE};
                cur_row_next   = '0;
                cur_col_next   = '0;
            end
            default:
            begin
                q_op.kind = tccw_pkg::CMD_NOP;
            end
        endcase
        q_op.cursor_row    = tccw_pkg::ROW_W'(cur_row_next);
        q_op.cursor_column = tccw_pkg::COL_W'(cur_col_next);
    end

    // cursor and default attribute registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            def_attr_reg <= tccw_pkg::DEFAULT_ATTR_RESET;
        end
        else
        begin
            if (q_push)
            begin
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
            end
            if (cfg_valid && cfg_ready)
                def_attr_reg <= cfg_data;
        end
    end

endmodule

// ----- design/tccw_queue.sv -----
// short first-in first-out queue between front and back end
`timescale 1ns / 1ps

module tccw_queue #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]              entry_reg [tccw_pkg::QUEUE_DEPTH];
    logic [tccw_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tccw_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    assign push_ready = (count_reg != (tccw_pkg::QUEUE_AW + 1)'(tccw_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- design/tccw_back.sv -----
// back end: cell memory, scroll and clear sweeps, result register
`timescale 1ns / 1ps

module tccw_back #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80,
    localparam int AW     = $clog2(ROWS * COLUMNS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  tccw_pkg::op_t               q_op,
    input  logic [AW-1:0]               q_addr,
    output logic                        q_pop,
    output logic                        init_done,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tccw_pkg::ROW_W-1:0]  cursor_row,
    output logic [tccw_pkg::COL_W-1:0]  cursor_column,
    output logic [tccw_pkg::CHAR_W-1:0] cell_char,
    output logic [tccw_pkg::ATTR_W-1:0] cell_attribute,
    output logic                        scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
    localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLUMNS);

    logic [tccw_pkg::CELL_W-1:0] mem [CELLS];

    tccw_pkg::back_state_t       state_reg, state_next;
    logic [AW-1:0]               cnt_reg;
    tccw_pkg::op_t               op_reg;
    logic [tccw_pkg::CELL_W-1:0] fill_data_reg;
    logic [tccw_pkg::CELL_W-1:0] rd_data_reg;
    logic                        copy_vld_reg;
    logic [AW-1:0]               copy_dst_reg;

    logic                        out_valid_reg;
    logic [tccw_pkg::ROW_W-1:0]  out_row_reg;
    logic [tccw_pkg::COL_W-1:0]  out_col_reg;
    logic [tccw_pkg::CHAR_W-1:0] out_char_reg;
    logic [tccw_pkg::ATTR_W-1:0] out_attr_reg;
    logic                        out_scroll_reg;

    logic                        slot_free, cnt_last;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr, mem_raddr;
    logic [tccw_pkg::CELL_W-1:0] mem_wdata;
    logic                        out_load, out_from_head, out_is_read;

    assign slot_free = !out_valid_reg || out_ready;
    assign cnt_last  = (cnt_reg == LAST_CELL);
    assign init_done = (state_reg != tccw_pkg::B_INIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tccw_pkg::B_INIT:
                if (cnt_last)
                    state_next = tccw_pkg::B_IDLE;
            tccw_pkg::B_IDLE:
                if (q_valid && slot_free)
                begin
                    case (q_op.kind)
                        tccw_pkg::CMD_PUT:
                            if (q_op.scroll)
                                state_next = tccw_pkg::B_COPY;
                        tccw_pkg::CMD_READ:  state_next = tccw_pkg::B_READ;
                        tccw_pkg::CMD_CLEAR: state_next = tccw_pkg::B_FILL;
                        default:             state_next = tccw_pkg::B_IDLE;
                    endcase
                end
            tccw_pkg::B_READ:
                state_next = tccw_pkg::B_IDLE;
            tccw_pkg::B_COPY:
                if (cnt_last)
                    state_next = tccw_pkg::B_DRAIN;
            tccw_pkg::B_DRAIN:
                state_next = tccw_pkg::B_FILL;
            tccw_pkg::B_FILL:
                if (cnt_last)
                    state_next = tccw_pkg::B_IDLE;
            default:
                state_next = tccw_pkg::B_IDLE;
        endcase
    end

    // outputs of the sequencer: pop, memory port, result load
    always_comb
    begin
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = fill_data_reg;
        mem_raddr     = q_addr;
        out_load      = 1'b0;
        out_from_head = 1'b0;
        out_is_read   = 1'b0;
        case (state_reg)
            tccw_pkg::B_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            tccw_pkg::B_IDLE:
            begin
                q_pop = q_valid && slot_free;
                if (q_pop && (q_op.kind == tccw_pkg::CMD_PUT) && q_op.write_en)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = q_addr;
                    mem_wdata = q_op.cell_data;
                end
                if (q_pop && (((q_op.kind == tccw_pkg::CMD_PUT) && !q_op.scroll)
                              || (q_op.kind == tccw_pkg::CMD_NOP)))
                begin
                    out_load      = 1'b1;
                    out_from_head = 1'b1;
                end
            end
            tccw_pkg::B_READ:
            begin
                out_load    = 1'b1;
                out_is_read = 1'b1;
            end
            tccw_pkg::B_COPY, tccw_pkg::B_DRAIN:
            begin
                mem_raddr = cnt_reg;
                mem_we    = copy_vld_reg;
                mem_waddr = copy_dst_reg;
                mem_wdata = rd_data_reg;
            end
            tccw_pkg::B_FILL:
            begin
                mem_we   = 1'b1;
                out_load = cnt_last;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer state, sweep counter and copy pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tccw_pkg::B_INIT;
            cnt_reg      <= '0;
            copy_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            copy_vld_reg <= (state_reg == tccw_pkg::B_COPY);
            case (state_reg)
                tccw_pkg::B_IDLE:
                    if (q_pop)
                        cnt_reg <= (q_op.kind == tccw_pkg::CMD_CLEAR) ? '0 : ROW_STEP;
                tccw_pkg::B_DRAIN:
                    cnt_reg <= BOTTOM_ROW;
                tccw_pkg::B_INIT, tccw_pkg::B_COPY, tccw_pkg::B_FILL:
                    cnt_reg <= AW'(cnt_reg + 1'b1);
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    // operation held during multi-cycle work
    always_ff @(posedge clk)
    begin
        copy_dst_reg <= AW'(cnt_reg - ROW_STEP);
        if (q_pop)
        begin
            op_reg <= q_op;
            if (q_op.kind == tccw_pkg::CMD_CLEAR)
                fill_data_reg <= q_op.cell_data;
            else
                fill_data_reg <= {q_op.cell_data[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W],
                                  tccw_pkg::SPACE_CODE};
        end
    end

    // cell memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (out_from_head)
            begin
                out_row_reg    <= q_op.cursor_row;
                out_col_reg    <= q_op.cursor_column;
                out_scroll_reg <= 1'b0;
            end
            else
            begin
                out_row_reg    <= op_reg.cursor_row;
                out_col_reg    <= op_reg.cursor_column;
                out_scroll_reg <= op_reg.scroll && (op_reg.kind == tccw_pkg::CMD_PUT);
            end
            if (out_is_read)
            begin
                out_char_reg <= rd_data_reg[tccw_pkg::CHAR_W-1:0];
                out_attr_reg <= rd_data_reg[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
            end
            else
            begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_row     = out_row_reg;
    assign cursor_column  = out_col_reg;
    assign cell_char      = out_char_reg;
    assign cell_attribute = out_attr_reg;
    assign scrolled       = out_scroll_reg;

endmodule

// ----- design/text_console_cell_writer.sv -----
// top level of the text console cell writer
//
// channel   direction   handshake              carries
// in        into block  in_valid / in_ready    command, char_code, use_position, row,
//                                               column, attribute
// out       from block  out_valid / out_ready  cursor_row, cursor_column, cell_char,
//                                               cell_attribute, scrolled
// cfg       into block  cfg_valid / cfg_ready  cfg_data (default attribute)
//
// a put that does not scroll ends in the back-end idle state; a read also passes the read
// state (registered memory read); a scrolling put copies rows up through the memory ports,
// then blanks the bottom row; a clear fills every cell
// after reset the back end zeroes the memory; no request is taken then
// a four-entry queue lets the front take requests while the back end sweeps or the
// result register waits on out_ready
`timescale 1ns / 1ps

module text_console_cell_writer #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tccw_pkg::CMD_W-1:0]  command,
    input  logic [tccw_pkg::CHAR_W-1:0] char_code,
    input  logic                        use_position,
    input  logic [tccw_pkg::ROW_W-1:0]  row,
    input  logic [tccw_pkg::COL_W-1:0]  column,
    input  logic [tccw_pkg::ATTR_W-1:0] attribute,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tccw_pkg::ROW_W-1:0]  cursor_row,
    output logic [tccw_pkg::COL_W-1:0]  cursor_column,
    output logic [tccw_pkg::CHAR_W-1:0] cell_char,
    output logic [tccw_pkg::ATTR_W-1:0] cell_attribute,
    output logic                        scrolled,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tccw_pkg::ATTR_W-1:0] cfg_data
);

    localparam int AW = $clog2(ROWS * COLUMNS);
    localparam int QW = $bits(tccw_pkg::op_t) + AW;

    logic          init_done;
    logic          push, push_ready, pop, pop_valid;
    tccw_pkg::op_t push_op, pop_op;
    logic [AW-1:0] push_addr, pop_addr;
    logic [QW-1:0] pop_word;

    // request intake and classification
    tccw_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .char_code    (char_code),
        .use_position (use_position),
        .row          (row),
        .column       (column),
        .attribute    (attribute),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .init_done    (init_done),
        .q_ready      (push_ready),
        .q_push       (push),
        .q_op         (push_op),
        .q_addr       (push_addr)
    );

    // operation queue
    tccw_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_op, push_addr}),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_word)
    );

    assign pop_op   = tccw_pkg::op_t'(pop_word[QW-1:AW]);
    assign pop_addr = pop_word[AW-1:0];

    // memory work and results
    tccw_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (pop_valid),
        .q_op           (pop_op),
        .q_addr         (pop_addr),
        .q_pop          (pop),
        .init_done      (init_done),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .scrolled       (scrolled)
    );

endmodule

// ----- verif/tb_text_console_cell_writer.sv -----
// self-checking testbench for the text console cell writer
`timescale 1ns / 1ps

module tb_text_console_cell_writer;

    import tccw_pkg::*;

    localparam int ROWS            = 25;
    localparam int COLUMNS         = 80;
    localparam int CELL_COUNT      = ROWS * COLUMNS;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 240;
    // a scroll or clear sweeps every cell; drain covers one more sweep
    localparam int DRAIN_CYCLES    = CELL_COUNT + 100;
    // every request a scroll with the longest gap and stall, several times over
    localparam longint LIMIT_CYCLES = 64'd16_000_000;

    // one request on the input channel
    typedef struct packed {
        cmd_t              command;
        logic [CHAR_W-1:0] char_code;
        logic              use_position;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [ATTR_W-1:0] attribute;
    } console_req_t;

    // one result on the output channel
    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attribute;
        logic              scrolled;
    } console_report_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic [CMD_W-1:0]  command        = '0;
    logic [CHAR_W-1:0] char_code      = '0;
    logic              use_position   = 1'b0;
    logic [ROW_W-1:0]  row            = '0;
    logic [COL_W-1:0]  column         = '0;
    logic [ATTR_W-1:0] attribute      = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attribute;
    logic              scrolled;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [ATTR_W-1:0] cfg_data       = '0;

    // shadow copy of the console
    logic [CELL_W-1:0] screen_cells [CELL_COUNT];
    int unsigned       cursor_pos  = 0;
    logic [ATTR_W-1:0] blank_attr  = DEFAULT_ATTR_RESET;

    console_req_t      console_requests [$];
    console_report_t   awaited_reports [$];

    int unsigned queued_total   = 0;
    int unsigned taken_total    = 0;
    int unsigned put_count      = 0;
    int unsigned read_count     = 0;
    int unsigned clear_count    = 0;
    int unsigned scroll_count   = 0;
    int unsigned cfg_writes     = 0;
    int unsigned mismatch_count = 0;
    int unsigned fail_count     = 0;
    longint      cycle_count    = 0;

    bit          in_accepted  = 1'b0;
    bit          out_accepted = 1'b0;
    bit          in_steady    = 1'b0;
    bit          out_steady   = 1'b0;
    int unsigned in_wait      = 0;
    int unsigned out_wait     = 0;

    text_console_cell_writer #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .char_code      (char_code),
        .use_position   (use_position),
        .row            (row),
        .column         (column),
        .attribute      (attribute),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor_row     (cursor_row),
        .cursor_column  (cursor_column),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .scrolled       (scrolled),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one request to the shadow console and work out its result
    task automatic update_console(input console_req_t req, output console_report_t rep);
        int unsigned       pos;
        int unsigned       row_sat;
        int unsigned       col_sat;
        logic [ATTR_W-1:0] put_attr;
        rep     = '0;
        row_sat = (req.row >= ROWS) ? ROWS - 1 : req.row;
        col_sat = (req.column >= COLUMNS) ? COLUMNS - 1 : req.column;
        case (req.command)
            CMD_PUT:
            begin
                put_count++;
                put_attr = (req.attribute != '0) ? req.attribute : blank_attr;
                pos = req.use_position ? row_sat * COLUMNS + col_sat : cursor_pos;
                // newline jumps to the end of its row, nothing stored
                if (req.char_code == NEWLINE_CODE)
                    pos = (pos / COLUMNS) * COLUMNS + COLUMNS - 1;
                else
                    screen_cells[pos] = {put_attr, req.char_code};
                pos++;
                // ran off the last cell: scroll up, blank bottom row in the put's attribute
                if (pos >= CELL_COUNT)
                begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_cells[i] = screen_cells[i + COLUMNS];
                    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_cells[i] = {put_attr, SPACE_CODE};
                    pos -= COLUMNS;
                    rep.scrolled = 1'b1;
                    scroll_count++;
                end
                cursor_pos = pos;
            end
            CMD_READ:
            begin
                read_count++;
                {rep.cell_attribute, rep.cell_char} = screen_cells[row_sat * COLUMNS + col_sat];
            end
            CMD_CLEAR:
            begin
                clear_count++;
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_cells[i] = {blank_attr, SPACE_CODE};
                cursor_pos = 0;
            end
            CMD_NOP:
            begin
            end
        endcase
        rep.cursor_row    = ROW_W'(cursor_pos / COLUMNS);
        rep.cursor_column = COL_W'(cursor_pos % COLUMNS);
    endtask

    task automatic queue_req(input cmd_t cmd, input logic [CHAR_W-1:0] ch, input logic up,
                             input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                             input logic [ATTR_W-1:0] at);
        console_req_t req;
        req.command      = cmd;
        req.char_code    = ch;
        req.use_position = up;
        req.row          = r;
        req.column       = c;
        req.attribute    = at;
        console_requests.push_back(req);
        queued_total++;
    endtask

    task automatic wait_console_idle();
        while (taken_total != queued_total || awaited_reports.size() != 0)
            @(negedge clk);
    endtask

    // request driver, changes inputs on the falling edge
    always @(negedge clk)
    begin
        console_req_t req;
        if (rst_n)
        begin
            if (in_accepted)
            begin
                if ($urandom_range(0, 39) == 0)
                    in_steady = !in_steady;
                in_wait = in_steady ? 0 : $urandom_range(0, 4);
            end
            if (in_valid && !in_accepted)
            begin
                // hold the request until it is taken
            end
            else if (in_wait == 0 && console_requests.size() != 0)
            begin
                req = console_requests.pop_front();
                in_valid     <= 1'b1;
                command      <= req.command;
                char_code    <= req.char_code;
                use_position <= req.use_position;
                row          <= req.row;
                column       <= req.column;
                attribute    <= req.attribute;
            end
            else
            begin
                in_valid <= 1'b0;
                if (in_wait > 0)
                    in_wait--;
            end
        end
    end

    // predict on each accepted request
    always @(posedge clk)
    begin
        console_req_t    req;
        console_report_t rep;
        in_accepted = rst_n && in_valid && in_ready;
        if (in_accepted)
        begin
            req.command      = cmd_t'(command);
            req.char_code    = char_code;
            req.use_position = use_position;
            req.row          = row;
            req.column       = column;
            req.attribute    = attribute;
            update_console(req, rep);
            awaited_reports.push_back(rep);
            taken_total++;
        end
    end

    // result ready with random stalls after each result
    always @(negedge clk)
    begin
        if (out_accepted)
        begin
            if ($urandom_range(0, 39) == 0)
                out_steady = !out_steady;
            out_wait = out_steady ? 0 : $urandom_range(0, 4);
        end
        if (out_wait > 0)
        begin
            out_ready <= 1'b0;
            out_wait--;
        end
        else
            out_ready <= 1'b1;
    end

    // compare each result with the oldest prediction
    always @(posedge clk)
    begin
        console_report_t got;
        console_report_t want;
        out_accepted = rst_n && out_valid && out_ready;
        if (out_accepted)
        begin
            got = {cursor_row, cursor_column, cell_char, cell_attribute, scrolled};
            if (awaited_reports.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("cycle %0d: result with nothing outstanding: row %0d col %0d",
                             cycle_count, got.cursor_row, got.cursor_column);
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (got.cursor_row !== want.cursor_row
                    || got.cursor_column !== want.cursor_column
                    || got.cell_char !== want.cell_char
                    || got.cell_attribute !== want.cell_attribute
                    || got.scrolled !== want.scrolled)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"cycle %0d: got row %0d col %0d char %02h attr %02h ",
                                  "scroll %0b, predicted row %0d col %0d char %02h attr %02h ",
                                  "scroll %0b"},
                                 cycle_count, got.cursor_row, got.cursor_column,
                                 got.cell_char, got.cell_attribute, got.scrolled,
                                 want.cursor_row, want.cursor_column, want.cell_char,
                                 want.cell_attribute, want.scrolled);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        int unsigned       pick;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] at;
        logic [ATTR_W-1:0] setting;
        logic [ROW_W-1:0]  r;
        logic [COL_W-1:0]  c;
        logic [ATTR_W-1:0] attr_settings [PHASES];
        attr_settings = '{8'h00, 8'hFF, 8'h4F, 8'h01, 8'h80, DEFAULT_ATTR_RESET, 8'h00};
        attr_settings[PHASES - 1] = ATTR_W'($urandom_range(0, 255));
        for (int i = 0; i < CELL_COUNT; i++)
            screen_cells[i] = '0;

        // reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed requests under the reset default attribute
        queue_req(CMD_READ,  8'h00, 1'b0, 5'd0,  7'd0,   8'h00);   // untouched cell reads zero
        queue_req(CMD_PUT,   8'h41, 1'b0, 5'd0,  7'd0,   8'h00);   // zero attribute picks default
        queue_req(CMD_PUT,   8'h00, 1'b0, 5'd31, 7'd127, 8'hFF);   // cursor put ignores position
        queue_req(CMD_PUT,   8'hFF, 1'b1, 5'd0,  7'd79,  8'h01);   // end of row wraps
        queue_req(CMD_PUT,   NEWLINE_CODE, 1'b0, 5'd0, 7'd0, 8'h22);
        queue_req(CMD_READ,  8'hFF, 1'b1, 5'd0,  7'd79,  8'hFF);
        queue_req(CMD_READ,  8'h00, 1'b0, 5'd31, 7'd127, 8'h00);   // both indices saturate
        queue_req(CMD_PUT,   8'h5A, 1'b1, 5'd31, 7'd127, 8'h70);   // last cell scrolls
        queue_req(CMD_READ,  8'h00, 1'b0, 5'd23, 7'd79,  8'h00);
        queue_req(CMD_READ,  8'h00, 1'b1, 5'd24, 7'd5,   8'h00);
        queue_req(CMD_PUT,   NEWLINE_CODE, 1'b1, 5'd24, 7'd3, 8'h00); // newline on bottom row
        queue_req(CMD_PUT,   8'h7E, 1'b1, 5'd5,  7'd100, 8'h0C);   // column saturates
        queue_req(CMD_PUT,   8'h23, 1'b1, 5'd25, 7'd0,   8'h00);   // row saturates
        queue_req(CMD_READ,  8'h00, 1'b1, 5'd5,  7'd127, 8'h00);
        queue_req(CMD_READ,  8'h00, 1'b0, 5'd24, 7'd0,   8'h00);
        queue_req(CMD_NOP,   8'hFF, 1'b1, 5'd31, 7'd127, 8'hFF);   // no-op keeps everything
        queue_req(CMD_PUT,   8'h20, 1'b0, 5'd0,  7'd0,   8'h00);
        queue_req(CMD_CLEAR, 8'h41, 1'b1, 5'd7,  7'd7,   8'hAA);   // clear homes the cursor
        queue_req(CMD_READ,  8'h00, 1'b0, 5'd12, 7'd40,  8'h00);
        queue_req(CMD_READ,  8'h00, 1'b0, 5'd24, 7'd79,  8'h00);
        queue_req(CMD_PUT,   8'h80, 1'b1, 5'd24, 7'd78,  8'h00);
        queue_req(CMD_PUT,   8'h7F, 1'b0, 5'd0,  7'd0,   8'hFF);   // third scroll, from the cursor
        queue_req(CMD_READ,  8'h00, 1'b1, 5'd23, 7'd78,  8'h00);
        wait_console_idle();

        // one phase of random traffic per default attribute setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            setting = attr_settings[phase];
            @(negedge clk);
            cfg_data  <= setting;
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            blank_attr = setting;
            cfg_writes++;
            @(negedge clk);
            cfg_valid <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                ch = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255));
                at = ($urandom_range(0, 3) == 0) ? '0 : ATTR_W'($urandom_range(0, 255));
                r  = ROW_W'($urandom_range(0, 31));
                c  = COL_W'($urandom_range(0, 127));
                if (pick < 52)
                    // text at the cursor, position fields are noise
                    queue_req(CMD_PUT, ch, 1'b0, r, c, at);
                else if (pick < 66)
                begin
                    // positioned puts, mostly near the bottom to provoke scrolling
                    if ($urandom_range(0, 1) == 0)
                        r = ROW_W'($urandom_range(20, 24));
                    if ($urandom_range(0, 2) == 0)
                        c = COL_W'($urandom_range(70, 79));
                    queue_req(CMD_PUT, ch, 1'b1, r, c, at);
                end
                else if (pick < 92)
                    queue_req(CMD_READ, CHAR_W'($urandom), 1'($urandom), r, c, at);
                else if (pick < 94)
                    queue_req(CMD_CLEAR, CHAR_W'($urandom), 1'($urandom), r, c, at);
                else
                    queue_req(CMD_NOP, CHAR_W'($urandom), 1'($urandom), r, c, at);
            end
            wait_console_idle();
        end

        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d puts, %0d reads, %0d clears, %0d scrolls",
                 taken_total, put_count, read_count, clear_count, scroll_count);
        $display("default attribute written %0d times, %0d mismatches", cfg_writes,
                 mismatch_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
